/* hw/rtl/edns_pkg.sv */
// ----------------------------------------------------------------------------
// edns_pkg
// Shared types and constants of the EDNS0 OPT record parser.
// ----------------------------------------------------------------------------
package edns_pkg;

  // Record type code of an OPT pseudo record
  localparam logic [15:0] OPT_TYPE = 16'd41;
  // Top two bits of a name byte that mark a compression pointer
  localparam logic [7:0]  PTR_MASK = 8'hC0;

  // Result kinds
  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  // One input transaction
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } edns_in_t;

  // One result transaction
  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic        is_opt;
    logic [15:0] udp_payload_size;
    logic [7:0]  extended_rcode;
    logic [7:0]  edns_version;
    logic [15:0] edns_flags;
    logic [15:0] data_length;
    logic        truncated;
  } edns_out_t;

  // Up to two results produced by one input byte, in order r0 then r1
  typedef struct packed {
    logic [1:0] cnt;
    edns_out_t  r0;
    edns_out_t  r1;
  } edns_push_t;

endpackage

/* hw/rtl/edns_parse.sv */
// ----------------------------------------------------------------------------
// edns_parse
// Byte-wise parser state: skips the owner name, gathers the fixed header
// fields and builds the data and done results for each accepted byte.
// ----------------------------------------------------------------------------
module edns_parse (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  edns_pkg::edns_in_t  in_item,
  output edns_pkg::edns_push_t push
);
  import edns_pkg::*;

  localparam logic [3:0] PH_NAME_LEN = 4'd0;
  localparam logic [3:0] PH_LABEL    = 4'd1;
  localparam logic [3:0] PH_PTR      = 4'd2;
  localparam logic [3:0] PH_TYPE     = 4'd3;
  localparam logic [3:0] PH_PSIZE    = 4'd4;
  localparam logic [3:0] PH_TTL      = 4'd5;
  localparam logic [3:0] PH_RDLEN    = 4'd6;
  localparam logic [3:0] PH_DATA     = 4'd7;
  localparam logic [3:0] PH_DRAIN    = 4'd8;

  logic [3:0]  phase_r,       phase_nxt;
  logic [7:0]  label_skip_r,  label_skip_nxt;
  logic [15:0] rec_type_r,    rec_type_nxt;
  logic [15:0] psize_r,       psize_nxt;
  logic [31:0] ttl_r,         ttl_nxt;
  logic [15:0] dlen_r,        dlen_nxt;
  logic [15:0] dleft_r,       dleft_nxt;
  logic [1:0]  fidx_r,        fidx_nxt;

  logic        done;
  logic        fld2_end;
  logic        fld4_end;
  logic        opt;
  logic        fin_opt;
  logic        fin_trunc;
  logic        fin_en;
  logic        data_en;
  logic [7:0]  b;
  edns_out_t   data_res;
  edns_out_t   fin_res;

  assign b        = in_item.data_byte;
  assign fld2_end = (fidx_r >= 2'd1);
  assign fld4_end = (fidx_r >= 2'd3);

  // Advance the parse state for one byte
  always_comb begin
    phase_nxt      = phase_r;
    label_skip_nxt = label_skip_r;
    rec_type_nxt   = rec_type_r;
    psize_nxt      = psize_r;
    ttl_nxt        = ttl_r;
    dlen_nxt       = dlen_r;
    dleft_nxt      = dleft_r;
    fidx_nxt       = fidx_r;
    done           = 1'b0;
    data_en        = 1'b0;
    case (phase_r)
      PH_NAME_LEN: begin
        if (b == 8'd0) begin
          phase_nxt = PH_TYPE;
          fidx_nxt  = 2'd0;
        end else if ((b & PTR_MASK) == PTR_MASK) begin
          phase_nxt = PH_PTR;
        end else begin
          label_skip_nxt = b;
          phase_nxt      = PH_LABEL;
        end
      end
      PH_LABEL: begin
        label_skip_nxt = label_skip_r - 8'd1;
        if (label_skip_nxt == 8'd0) phase_nxt = PH_NAME_LEN;
      end
      PH_PTR: begin
        phase_nxt = PH_TYPE;
        fidx_nxt  = 2'd0;
      end
      PH_TYPE: begin
        rec_type_nxt = {rec_type_r[7:0], b};
        fidx_nxt     = fld2_end ? 2'd0 : fidx_r + 2'd1;
        if (fld2_end) phase_nxt = PH_PSIZE;
      end
      PH_PSIZE: begin
        psize_nxt = {psize_r[7:0], b};
        fidx_nxt  = fld2_end ? 2'd0 : fidx_r + 2'd1;
        if (fld2_end) phase_nxt = PH_TTL;
      end
      PH_TTL: begin
        ttl_nxt  = {ttl_r[23:0], b};
        fidx_nxt = fld4_end ? 2'd0 : fidx_r + 2'd1;
        if (fld4_end) phase_nxt = PH_RDLEN;
      end
      PH_RDLEN: begin
        dlen_nxt = {dlen_r[7:0], b};
        fidx_nxt = fld2_end ? 2'd0 : fidx_r + 2'd1;
        if (fld2_end) begin
          dleft_nxt = dlen_nxt;
          if (dlen_nxt == 16'd0) done = 1'b1;
          else                   phase_nxt = PH_DATA;
        end
      end
      PH_DATA: begin
        data_en   = (rec_type_r == OPT_TYPE);
        dleft_nxt = dleft_r - 16'd1;
        if (dleft_nxt == 16'd0) done = 1'b1;
      end
      default: begin
      end
    endcase

    // Decide on the final result from the updated phase
    fin_en    = 1'b0;
    fin_trunc = 1'b0;
    fin_opt   = 1'b0;
    if (done) begin
      fin_en  = 1'b1;
      fin_opt = (rec_type_nxt == OPT_TYPE);
    end else if (in_item.last_byte) begin
      if (phase_nxt == PH_DATA) begin
        fin_en    = 1'b1;
        fin_trunc = 1'b1;
        fin_opt   = (rec_type_nxt == OPT_TYPE);
      end else if (phase_nxt != PH_DRAIN) begin
        fin_en    = 1'b1;
        fin_trunc = 1'b1;
      end
    end
    if (done && !in_item.last_byte) phase_nxt = PH_DRAIN;
  end

  assign opt = fin_opt;

  // Build the data byte result and the record done result
  always_comb begin
    data_res              = '0;
    data_res.kind         = KIND_DATA;
    data_res.payload_byte = b;

    fin_res           = '0;
    fin_res.kind      = KIND_DONE;
    fin_res.truncated = fin_trunc;
    if (opt) begin
      fin_res.is_opt           = 1'b1;
      fin_res.udp_payload_size = psize_nxt;
      fin_res.extended_rcode   = ttl_nxt[31:24];
      fin_res.edns_version     = ttl_nxt[23:16];
      fin_res.edns_flags       = ttl_nxt[15:0];
      fin_res.data_length      = dlen_nxt - dleft_nxt;
    end
  end

  // Pack results in delivery order
  always_comb begin
    push = '0;
    if (accept) begin
      if (data_en && fin_en) begin
        push.cnt = 2'd2;
        push.r0  = data_res;
        push.r1  = fin_res;
      end else if (data_en) begin
        push.cnt = 2'd1;
        push.r0  = data_res;
      end else if (fin_en) begin
        push.cnt = 2'd1;
        push.r0  = fin_res;
      end
    end
  end

  // Hold state between bytes; restart on the buffer's last byte
  always_ff @(posedge clk) begin
    if (!rst_n || (accept && in_item.last_byte)) begin
      phase_r      <= PH_NAME_LEN;
      label_skip_r <= '0;
      rec_type_r   <= '0;
      psize_r      <= '0;
      ttl_r        <= '0;
      dlen_r       <= '0;
      dleft_r      <= '0;
      fidx_r       <= '0;
    end else if (accept) begin
      phase_r      <= phase_nxt;
      label_skip_r <= label_skip_nxt;
      rec_type_r   <= rec_type_nxt;
      psize_r      <= psize_nxt;
      ttl_r        <= ttl_nxt;
      dlen_r       <= dlen_nxt;
      dleft_r      <= dleft_nxt;
      fidx_r       <= fidx_nxt;
    end
  end

`ifndef SYNTHESIS
  a_two_in_order: assert property (@(posedge clk) disable iff (!rst_n)
    (push.cnt == 2'd2) |-> (push.r0.kind == KIND_DATA && push.r1.kind == KIND_DONE))
    else $error("two results not ordered data then done");

  a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_item.last_byte) |=> (phase_r == PH_NAME_LEN && fidx_r == 2'd0))
    else $error("parser did not restart after last byte");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    (push.cnt != 2'd0) |-> accept)
    else $error("result produced without an input transaction");
`endif

endmodule

/* hw/rtl/edns_outq.sv */
// ----------------------------------------------------------------------------
// edns_outq
// Three-entry result queue; takes up to two results per cycle while room is
// high and delivers one per output transaction.
// ----------------------------------------------------------------------------
module edns_outq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  edns_pkg::edns_push_t push,
  output logic                 room,
  output logic                 out_valid,
  input  logic                 out_stall,
  output edns_pkg::edns_out_t  out_data
);
  import edns_pkg::*;

  edns_out_t  mem_r [3];
  logic [1:0] count_r, count_nxt;
  logic [1:0] wr_ptr_r, wr_ptr_nxt;
  logic [1:0] rd_ptr_r, rd_ptr_nxt;
  logic [1:0] wr_ptr_p1;
  logic       pop;

  function automatic logic [1:0] inc3(input logic [1:0] p);
    inc3 = (p == 2'd2) ? 2'd0 : p + 2'd1;
  endfunction

  assign out_valid = (count_r != 2'd0);
  assign out_data  = mem_r[rd_ptr_r];
  assign pop       = out_valid && !out_stall;
  // Take an item only while two slots are guaranteed free
  assign room      = (count_r <= 2'd1);
  assign wr_ptr_p1 = inc3(wr_ptr_r);

  // Advance pointers and occupancy
  always_comb begin
    count_nxt  = count_r + push.cnt - {1'b0, pop};
    rd_ptr_nxt = pop ? inc3(rd_ptr_r) : rd_ptr_r;
    case (push.cnt)
      2'd1:    wr_ptr_nxt = wr_ptr_p1;
      2'd2:    wr_ptr_nxt = inc3(wr_ptr_p1);
      default: wr_ptr_nxt = wr_ptr_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      count_r  <= count_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  // Write the entries
  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) mem_r[wr_ptr_r]  <= push.r0;
    if (push.cnt == 2'd2) mem_r[wr_ptr_p1] <= push.r1;
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push.cnt != 2'd0) |-> (count_r <= 2'd1))
    else $error("result queue overflow");

  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n |=> (count_r == 2'($past(count_r) + $past(push.cnt) - {1'b0, $past(pop)})))
    else $error("result queue count mismatch");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == 2'd0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("empty queue with pointers apart");
`endif

endmodule

/* hw/rtl/edns_opt_record_parser_core.sv */
// ----------------------------------------------------------------------------
// edns_opt_record_parser_core
// EDNS0 OPT resource record parser, one record byte per input transaction.
// ----------------------------------------------------------------------------
// The block takes one byte per cycle while in_stall is low. Each accepted
// byte updates the registered parse state; its results (none, one, or two)
// enter a three-entry output queue. Most bytes yield at most one result, so
// the sustained rate is one byte per cycle while out_stall is low; the final
// data byte of an OPT record yields both a data result and a done result.
// in_stall rises while the queue holds two or more results, so a byte is
// accepted only when both of its possible results fit.
module edns_opt_record_parser_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  edns_pkg::edns_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output edns_pkg::edns_out_t out_data
);
  import edns_pkg::*;

  edns_push_t push;
  logic       room;
  logic       accept;

  // Accept an input transaction when the queue has room for two results
  assign in_stall = !room;
  assign accept   = in_valid && room;

  edns_parse u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_item (in_data),
    .push    (push)
  );

  edns_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
